// ===== hdl/lpf_pkg.sv =====
// package for the largest prime factor block: widths, microcode and shared types
package lpf_pkg;

  localparam int VALUE_BITS = 32;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);
  localparam int PC_BITS    = 5;

  localparam logic [VALUE_BITS-1:0] FIRST_ODD = VALUE_BITS'(3);
  localparam logic [VALUE_BITS-1:0] D_STEP    = VALUE_BITS'(2);
  localparam logic [VALUE_BITS-1:0] TWO       = VALUE_BITS'(2);
  localparam logic [VALUE_BITS-1:0] ONE       = VALUE_BITS'(1);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_HALVE,
    OP_SETD,
    OP_DIV,
    OP_TAKE,
    OP_SETNQ,
    OP_INCD,
    OP_BESTN,
    OP_DONE
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_N_LE1,
    COND_N_ODD,
    COND_DIV_BUSY,
    COND_D_GT_Q,
    COND_R_NZ
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [PC_BITS-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic load;
    op_e  op;
  } ctrl_t;

  typedef struct packed {
    logic n_le1;
    logic n_odd;
    logic div_busy;
    logic d_gt_q;
    logic r_nz;
  } status_t;

  localparam logic [PC_BITS-1:0] PC_CAND   = PC_BITS'(4);
  localparam logic [PC_BITS-1:0] PC_ODD    = PC_BITS'(3);
  localparam logic [PC_BITS-1:0] PC_STRIP  = PC_BITS'(1);
  localparam logic [PC_BITS-1:0] PC_WAIT1  = PC_BITS'(6);
  localparam logic [PC_BITS-1:0] PC_INNER  = PC_BITS'(10);
  localparam logic [PC_BITS-1:0] PC_WAIT2  = PC_BITS'(11);
  localparam logic [PC_BITS-1:0] PC_NEXT   = PC_BITS'(14);
  localparam logic [PC_BITS-1:0] PC_FINAL  = PC_BITS'(15);
  localparam logic [PC_BITS-1:0] PC_DONE   = PC_BITS'(17);
  localparam logic [PC_BITS-1:0] PC_NONE   = PC_BITS'(0);

  function automatic ucode_t ucode_rom(input logic [PC_BITS-1:0] pc);
    ucode_t w;
    unique case (pc)
      5'd0:    w = '{OP_NOP,   COND_N_LE1,    PC_DONE};
      5'd1:    w = '{OP_NOP,   COND_N_ODD,    PC_ODD};
      5'd2:    w = '{OP_HALVE, COND_ALWAYS,   PC_STRIP};
      5'd3:    w = '{OP_SETD,  COND_NEVER,    PC_NONE};
      5'd4:    w = '{OP_NOP,   COND_N_LE1,    PC_FINAL};
      5'd5:    w = '{OP_DIV,   COND_NEVER,    PC_NONE};
      5'd6:    w = '{OP_NOP,   COND_DIV_BUSY, PC_WAIT1};
      5'd7:    w = '{OP_NOP,   COND_D_GT_Q,   PC_FINAL};
      5'd8:    w = '{OP_NOP,   COND_R_NZ,     PC_NEXT};
      5'd9:    w = '{OP_TAKE,  COND_NEVER,    PC_NONE};
      5'd10:   w = '{OP_DIV,   COND_NEVER,    PC_NONE};
      5'd11:   w = '{OP_NOP,   COND_DIV_BUSY, PC_WAIT2};
      5'd12:   w = '{OP_NOP,   COND_R_NZ,     PC_NEXT};
      5'd13:   w = '{OP_SETNQ, COND_ALWAYS,   PC_INNER};
      5'd14:   w = '{OP_INCD,  COND_ALWAYS,   PC_CAND};
      5'd15:   w = '{OP_NOP,   COND_N_LE1,    PC_DONE};
      5'd16:   w = '{OP_BESTN, COND_NEVER,    PC_NONE};
      5'd17:   w = '{OP_DONE,  COND_NEVER,    PC_NONE};
      default: w = '{OP_DONE,  COND_NEVER,    PC_NONE};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/lpf_div.sv =====
// restoring divider, one quotient bit per cycle
module lpf_div
  import lpf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [VALUE_BITS-1:0] divisor_i,
  output logic                  busy_o,
  output logic [VALUE_BITS-1:0] quo_o,
  output logic [VALUE_BITS-1:0] rem_o
);

  logic                  busy_q, busy_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] rem_q, rem_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [VALUE_BITS-1:0] dvs_q, dvs_d;
  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS:0]   diff;

  assign shifted = {rem_q, quo_q[VALUE_BITS-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_BITS'(VALUE_BITS - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[VALUE_BITS]) begin
        rem_d = diff[VALUE_BITS-1:0];
        quo_d = {quo_q[VALUE_BITS-2:0], 1'b1};
      end else begin
        rem_d = shifted[VALUE_BITS-1:0];
        quo_d = {quo_q[VALUE_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== hdl/lpf_dp.sv =====
// datapath: cofactor, candidate, best factor and result registers
module lpf_dp
  import lpf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_t                 ctrl_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output status_t               status_o,
  output logic                  valid_o,
  output logic [VALUE_BITS-1:0] largest_factor_o
);

  logic [VALUE_BITS-1:0] n_q, n_d;
  logic [VALUE_BITS-1:0] d_q, d_d;
  logic [VALUE_BITS-1:0] best_q, best_d;
  logic [VALUE_BITS-1:0] res_q, res_d;
  logic                  valid_q, valid_d;
  logic                  div_busy;
  logic [VALUE_BITS-1:0] quo;
  logic [VALUE_BITS-1:0] rem;

  lpf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.op == OP_DIV),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .busy_o     (div_busy),
    .quo_o      (quo),
    .rem_o      (rem)
  );

  always_comb begin
    n_d     = n_q;
    d_d     = d_q;
    best_d  = best_q;
    res_d   = res_q;
    valid_d = 1'b0;
    if (ctrl_i.load) begin
      n_d    = value_i;
      best_d = ONE;
    end else begin
      unique case (ctrl_i.op)
        OP_HALVE: begin
          n_d    = n_q >> 1;
          best_d = TWO;
        end
        OP_SETD:  d_d = FIRST_ODD;
        OP_TAKE: begin
          best_d = d_q;
          n_d    = quo;
        end
        OP_SETNQ: n_d = quo;
        OP_INCD:  d_d = d_q + D_STEP;
        OP_BESTN: best_d = n_q;
        OP_DONE: begin
          res_d   = best_q;
          valid_d = 1'b1;
        end
        OP_NOP, OP_DIV: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    d_q    <= d_d;
    best_q <= best_d;
    res_q  <= res_d;
  end

  assign status_o.n_le1    = (n_q < TWO);
  assign status_o.n_odd    = n_q[0];
  assign status_o.div_busy = div_busy;
  assign status_o.d_gt_q   = (d_q > quo);
  assign status_o.r_nz     = (rem != '0);

  assign valid_o          = valid_q;
  assign largest_factor_o = res_q;

endmodule

// ===== hdl/lpf_seq.sv =====
// microcode sequencer: step counter, control rom and conditional jumps
module lpf_seq
  import lpf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output ctrl_t   ctrl_o,
  output logic    busy_o
);

  logic               busy_q, busy_d;
  logic [PC_BITS-1:0] pc_q, pc_d;
  ucode_t             word;
  logic               jump;

  assign word = ucode_rom(pc_q);

  always_comb begin
    unique case (word.cond)
      COND_NEVER:    jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_N_LE1:    jump = status_i.n_le1;
      COND_N_ODD:    jump = status_i.n_odd;
      COND_DIV_BUSY: jump = status_i.div_busy;
      COND_D_GT_Q:   jump = status_i.d_gt_q;
      COND_R_NZ:     jump = status_i.r_nz;
      default:       jump = 1'b0;
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    ctrl_o.load = 1'b0;
    ctrl_o.op   = OP_NOP;
    if (!busy_q) begin
      if (start_i) begin
        busy_d      = 1'b1;
        pc_d        = '0;
        ctrl_o.load = 1'b1;
      end
    end else begin
      ctrl_o.op = word.op;
      pc_d      = jump ? word.target : pc_q + PC_BITS'(1);
      if (word.op == OP_DONE) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  assign busy_o = busy_q;

endmodule

// ===== hdl/largest_prime_factor_top.sv =====
// Largest prime factor by trial division. A request is taken when start is high and busy
// is low; the answer appears on largest_factor_o for one cycle with valid_o high, and the
// receiver cannot stall it. Values below 2 answer 1. Otherwise the factors of two are stripped
// first, and then every odd candidate d is tried while d*d stays within the remaining
// cofactor, each with a division by the bit-serial divider behind the microcode loop; a
// repeated factor costs an extra division for each repeat. busy goes high after the request
// is taken and falls when the result is shown.
module largest_prime_factor_top
  import lpf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  busy,
  output logic                  valid_o,
  output logic [VALUE_BITS-1:0] largest_factor_o
);

  ctrl_t   ctrl;
  status_t status;

  lpf_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy)
  );

  lpf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .value_i          (value_i),
    .status_o         (status),
    .valid_o          (valid_o),
    .largest_factor_o (largest_factor_o)
  );

endmodule
